FILE: src/icmp_rx_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the ICMP receive classifier.
// Used by every module under src; depends on nothing else.
package icmp_rx_pkg;

	localparam int IN_TDATA_W  = 8;
	localparam int IN_TUSER_W  = 8;
	localparam int OUT_TDATA_W = 80;
	localparam int OUT_TUSER_W = 3;

	// Verdict codes
	localparam logic [2:0] VERDICT_DROP_SHORT    = 3'd0;
	localparam logic [2:0] VERDICT_DROP_PROTOCOL = 3'd1;
	localparam logic [2:0] VERDICT_DROP_CHECKSUM = 3'd2;
	localparam logic [2:0] VERDICT_PASS          = 3'd3;
	localparam logic [2:0] VERDICT_PASS_ECHO     = 3'd4;
	localparam logic [2:0] VERDICT_PASS_ERROR    = 3'd5;

	// Protocol, ICMP type and code values
	localparam logic [7:0] PROTO_ICMP          = 8'd1;
	localparam logic [7:0] TYPE_DEST_UNREACH   = 8'd3;
	localparam logic [7:0] TYPE_ECHO_REQUEST   = 8'd8;
	localparam logic [7:0] TYPE_TIME_EXCEEDED  = 8'd11;
	localparam logic [7:0] CODE_ZERO           = 8'd0;
	localparam logic [7:0] CODE_HOST_UNREACH   = 8'd1;
	localparam logic [7:0] CODE_PORT_UNREACH   = 8'd3;

	localparam logic [5:0]  MIN_HEADER_LEN = 6'd20;
	localparam logic [15:0] ICMP_HDR_LEN   = 16'd8;
	localparam logic [15:0] MIN_INNER_LEN  = 16'd20;
	localparam logic [15:0] OFFSET_MAX     = 16'hFFFF;
	localparam logic [15:0] SUM_ALL_ONES   = 16'hFFFF;

	typedef struct packed {
		logic [7:0] protocol;
		logic       last_byte;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  inner_protocol;
		logic        error_kind;
		logic [15:0] echo_sequence;
		logic [15:0] echo_ident;
		logic [15:0] payload_length;
		logic [7:0]  icmp_code;
		logic [7:0]  msg_type;
		logic [2:0]  verdict;
	} result_t;

	// Ones'-complement 16-bit add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] word);
		logic [16:0] s;
		s = {1'b0, acc} + {1'b0, word};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

FILE: src/icmp_rx_in_stage.sv
`timescale 1ns / 1ps
// Input register stage of the ICMP receive classifier.
// Depends on icmp_rx_pkg.
module icmp_rx_in_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  icmp_rx_pkg::in_item_t in_item,
	input  logic                  consume,
	output logic                  valid_s1,
	output icmp_rx_pkg::in_item_t item_s1
);
	import icmp_rx_pkg::*;

	// Take a new byte whenever the stage is empty or drains this cycle
	assign in_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: src/icmp_rx_parse.sv
`timescale 1ns / 1ps
// Per-byte header parsing, checksum accumulation and final verdict.
// Depends on icmp_rx_pkg.
module icmp_rx_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  icmp_rx_pkg::in_item_t item_s1,
	input  logic                  out_free,
	output logic                  consume,
	output logic                  done,
	output icmp_rx_pkg::result_t  result
);
	import icmp_rx_pkg::*;

	logic [15:0] offset_q, total_len_q, acc_q, ident_q, seq_q;
	logic [5:0]  hdr_len_q;
	logic [7:0]  pend_q, type_q, code_q, inner_q, proto_q;
	logic        csum_zero_q;

	logic [15:0] offset_n, total_len_n, acc_n, ident_n, seq_n;
	logic [5:0]  hdr_len_n;
	logic [7:0]  pend_n, type_n, code_n, inner_n, proto_n;
	logic        csum_zero_n;

	logic [7:0]  b;
	logic        in_region;
	logic [15:0] k;
	logic        len_ok;
	logic [15:0] msg_len;
	logic [15:0] payload;
	logic [16:0] received;
	logic [15:0] final_sum;
	logic        short;
	logic        err_msg;

	assign b = item_s1.data_byte;

	// A last byte needs a free result slot; other bytes always drain
	assign consume = valid_s1 && (!item_s1.last_byte || out_free);
	assign done    = consume && item_s1.last_byte;

	always_comb begin
		hdr_len_n   = hdr_len_q;
		total_len_n = total_len_q;
		acc_n       = acc_q;
		pend_n      = pend_q;
		type_n      = type_q;
		code_n      = code_q;
		csum_zero_n = csum_zero_q;
		ident_n     = ident_q;
		seq_n       = seq_q;
		inner_n     = inner_q;
		proto_n     = proto_q;

		if (offset_q == 16'd0) begin
			total_len_n = 16'd0;
			hdr_len_n   = {b[3:0], 2'b00};
			acc_n       = 16'd0;
			pend_n      = 8'd0;
			type_n      = 8'd0;
			code_n      = 8'd0;
			csum_zero_n = 1'b1;
			ident_n     = 16'd0;
			seq_n       = 16'd0;
			inner_n     = 8'd0;
			proto_n     = item_s1.protocol;
		end else if (offset_q == 16'd2) begin
			total_len_n = {b, 8'h00};
		end else if (offset_q == 16'd3) begin
			total_len_n = {total_len_q[15:8], b};
		end

		in_region = (hdr_len_n >= MIN_HEADER_LEN) && (offset_q >= {10'd0, hdr_len_n})
			&& (offset_q < total_len_n);
		k = offset_q - {10'd0, hdr_len_n};

		if (in_region) begin
			if (!k[0]) begin
				pend_n = b;
			end else begin
				acc_n = oc_add(acc_n, {pend_n, b});
			end
			case (k)
				16'd0: type_n = b;
				16'd1: code_n = b;
				16'd2, 16'd3: begin
					if (b != 8'd0) csum_zero_n = 1'b0;
				end
				16'd4: ident_n = {b, ident_n[7:0]};
				16'd5: ident_n = {ident_n[15:8], b};
				16'd6: seq_n = {b, seq_n[7:0]};
				16'd7: seq_n = {seq_n[15:8], b};
				16'd17: inner_n = b;
				default: ;
			endcase
		end

		if (item_s1.last_byte) begin
			offset_n = 16'd0;
		end else if (offset_q != OFFSET_MAX) begin
			offset_n = offset_q + 16'd1;
		end else begin
			offset_n = offset_q;
		end

		// Verdict from the state as it stands after this byte
		len_ok   = (hdr_len_n >= MIN_HEADER_LEN) && (total_len_n >= {10'd0, hdr_len_n});
		msg_len  = len_ok ? (total_len_n - {10'd0, hdr_len_n}) : 16'd0;
		payload  = (msg_len >= ICMP_HDR_LEN) ? (msg_len - ICMP_HDR_LEN) : 16'd0;
		received = {1'b0, offset_q} + 17'd1;
		final_sum = msg_len[0] ? oc_add(acc_n, {pend_n, 8'h00}) : acc_n;
		short = !len_ok || (received < {1'b0, total_len_n}) || (msg_len < ICMP_HDR_LEN);
		err_msg = ((type_n == TYPE_DEST_UNREACH)
			&& (code_n == CODE_HOST_UNREACH || code_n == CODE_PORT_UNREACH))
			|| (type_n == TYPE_TIME_EXCEEDED && code_n == CODE_ZERO);

		if (short) begin
			result.verdict = VERDICT_DROP_SHORT;
		end else if (proto_n != PROTO_ICMP) begin
			result.verdict = VERDICT_DROP_PROTOCOL;
		end else if (!csum_zero_n && final_sum != SUM_ALL_ONES) begin
			result.verdict = VERDICT_DROP_CHECKSUM;
		end else if (type_n == TYPE_ECHO_REQUEST && code_n == CODE_ZERO) begin
			result.verdict = VERDICT_PASS_ECHO;
		end else if (err_msg && payload >= MIN_INNER_LEN) begin
			result.verdict = VERDICT_PASS_ERROR;
		end else begin
			result.verdict = VERDICT_PASS;
		end

		result.msg_type       = type_n;
		result.icmp_code      = code_n;
		result.payload_length = payload;
		result.echo_ident     = ident_n;
		result.echo_sequence  = seq_n;
		result.error_kind     = (type_n == TYPE_TIME_EXCEEDED);
		result.inner_protocol = inner_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= 16'd0;
			total_len_q <= 16'd0;
			hdr_len_q   <= 6'd0;
			acc_q       <= 16'd0;
			pend_q      <= 8'd0;
			type_q      <= 8'd0;
			code_q      <= 8'd0;
			csum_zero_q <= 1'b1;
			ident_q     <= 16'd0;
			seq_q       <= 16'd0;
			inner_q     <= 8'd0;
			proto_q     <= 8'd0;
		end else if (consume) begin
			offset_q    <= offset_n;
			total_len_q <= total_len_n;
			hdr_len_q   <= hdr_len_n;
			acc_q       <= acc_n;
			pend_q      <= pend_n;
			type_q      <= type_n;
			code_q      <= code_n;
			csum_zero_q <= csum_zero_n;
			ident_q     <= ident_n;
			seq_q       <= seq_n;
			inner_q     <= inner_n;
			proto_q     <= proto_n;
		end
	end

endmodule

FILE: src/icmp_rx_out_stage.sv
`timescale 1ns / 1ps
// Result register of the ICMP receive classifier.
// Depends on icmp_rx_pkg.
module icmp_rx_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  icmp_rx_pkg::result_t result,
	output logic                 out_free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output icmp_rx_pkg::result_t out_result
);
	import icmp_rx_pkg::*;

	logic valid_q;
	result_t result_q;

	// Slot frees up in the same cycle its transfer completes
	assign out_free   = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_free) begin
			result_q <= result;
		end
	end

endmodule

FILE: src/icmp_rx_classifier.sv
`timescale 1ns / 1ps
// Top level of the ICMP receive classifier: input register, parser, result register.
// Depends on icmp_rx_pkg, icmp_rx_in_stage, icmp_rx_parse, icmp_rx_out_stage.
//
//  port group  dir  payload
//  s_axis_*    in   tdata = data_byte, tlast = last_byte, tuser = protocol
//  m_axis_*    out  tuser = verdict, tdata = type, code, payload length, ident,
//                   sequence, error kind, inner protocol
//
// One byte per cycle but for a held last byte; a verdict passes the input, then the result register.
// The per-byte state update and verdict logic sit between the input and result registers.
// A last byte waits in the input register while the result register is held by
// m_axis_tready low; other bytes keep flowing.
// Reset (arst_n) empties both registers and clears the parse state.
module icmp_rx_classifier (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [icmp_rx_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [7:0] data_byte
	input  logic                                   s_axis_tlast,
	input  logic [icmp_rx_pkg::IN_TUSER_W-1:0]     s_axis_tuser,  // [7:0] protocol
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// [7:0] msg_type, [15:8] icmp_code, [31:16] payload_length, [47:32] echo_ident,
	// [63:48] echo_sequence, [64] error_kind, [72:65] inner_protocol, [79:73] zero
	output logic [icmp_rx_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic [icmp_rx_pkg::OUT_TUSER_W-1:0]    m_axis_tuser   // [2:0] verdict
);
	import icmp_rx_pkg::*;

	in_item_t in_item, item_s1;
	result_t  result, out_result;
	logic     valid_s1, consume, done, out_free;

	assign in_item.data_byte = s_axis_tdata;
	assign in_item.last_byte = s_axis_tlast;
	assign in_item.protocol  = s_axis_tuser;

	icmp_rx_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.consume  (consume),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	icmp_rx_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.consume  (consume),
		.done     (done),
		.result   (result)
	);

	icmp_rx_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (done),
		.result     (result),
		.out_free   (out_free),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (out_result)
	);

	assign m_axis_tuser = out_result.verdict;
	assign m_axis_tdata = {7'd0, out_result.inner_protocol, out_result.error_kind,
		out_result.echo_sequence, out_result.echo_ident, out_result.payload_length,
		out_result.icmp_code, out_result.msg_type};

	a_last_waits_for_slot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.last_byte && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("last byte drained while result register was held");

	a_echo_type: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == VERDICT_PASS_ECHO
		|-> m_axis_tdata[7:0] == TYPE_ECHO_REQUEST && m_axis_tdata[15:8] == CODE_ZERO)
		else $error("echo verdict on a message that is not an echo request");

	a_error_fits: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == VERDICT_PASS_ERROR
		|-> m_axis_tdata[31:16] >= MIN_INNER_LEN)
		else $error("error verdict without room for an embedded header");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(done))
		else $error("result appeared without a finished packet");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for icmp_rx_classifier: directed and random IPv4/ICMP byte streams
// checked against a byte-level classifier model kept in this file. Depends on icmp_rx_pkg.
module testbench;
	import icmp_rx_pkg::*;

	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int ITEM_TARGET    = 1050;
	localparam int RANDOM_PACKETS = 3;

	logic clk;
	logic arst_n = 1'b0;

	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [7:0] data_byte
	logic                   s_axis_tlast = 1'b0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // [7:0] protocol
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [7:0] msg_type, [15:8] icmp_code, [31:16] payload_length, [47:32] echo_ident,
	// [63:48] echo_sequence, [64] error_kind, [72:65] inner_protocol, [79:73] zero
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;        // [2:0] verdict

	icmp_rx_classifier DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	result_t    pending_verdicts[$];
	logic [7:0] frame[$];
	int         mismatch_count = 0;
	int         bytes_sent = 0;
	int         cycle_count = 0;
	int         sink_hold = 0;
	bit         src_idling = 1'b1;
	bit         sink_idling = 1'b1;

	// Parser state of the classifier model
	logic [15:0] cur_offset = '0;
	logic [15:0] cur_total = '0;
	logic [5:0]  cur_hlen = '0;
	logic [15:0] cur_sum = '0;
	logic [7:0]  cur_high = '0;
	logic [7:0]  cur_type = '0;
	logic [7:0]  cur_code = '0;
	logic        cur_csum_zero = 1'b1;
	logic [15:0] cur_ident = '0;
	logic [15:0] cur_seq = '0;
	logic [7:0]  cur_inner = '0;
	logic [7:0]  cur_proto = '0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] word);
		logic [16:0] s;
		s = {1'b0, acc} + {1'b0, word};
		if (s[16])
			s = {1'b0, s[15:0]} + 17'd1;
		return s[15:0];
	endfunction

	// Advance the model by one byte; return 1 with the verdict when the byte closes a packet.
	function automatic bit classify_byte(input logic [7:0] b, input logic is_last,
		input logic [7:0] proto, output result_t res);
		logic [15:0] k;
		logic [15:0] s;
		int received;
		int msg_len;
		int payload;
		bit len_ok;
		res = '0;
		if (cur_offset == 16'd0) begin
			cur_total = '0;
			cur_hlen = {b[3:0], 2'b00};
			cur_sum = '0;
			cur_high = '0;
			cur_type = '0;
			cur_code = '0;
			cur_csum_zero = 1'b1;
			cur_ident = '0;
			cur_seq = '0;
			cur_inner = '0;
			cur_proto = proto;
		end else if (cur_offset == 16'd2) begin
			cur_total = {b, 8'h00};
		end else if (cur_offset == 16'd3) begin
			cur_total[7:0] = b;
		end

		if (cur_hlen >= MIN_HEADER_LEN && cur_offset >= {10'd0, cur_hlen} &&
			cur_offset < cur_total) begin
			k = cur_offset - {10'd0, cur_hlen};
			if (!k[0])
				cur_high = b;
			else
				cur_sum = fold_add(cur_sum, {cur_high, b});
			case (k)
				16'd0: cur_type = b;
				16'd1: cur_code = b;
				16'd2, 16'd3: if (b != 8'h00) cur_csum_zero = 1'b0;
				16'd4: cur_ident[15:8] = b;
				16'd5: cur_ident[7:0] = b;
				16'd6: cur_seq[15:8] = b;
				16'd7: cur_seq[7:0] = b;
				16'd17: cur_inner = b;
				default: ;
			endcase
		end

		if (!is_last) begin
			if (cur_offset != OFFSET_MAX)
				cur_offset = cur_offset + 16'd1;
			return 1'b0;
		end

		received = int'(cur_offset) + 1;
		len_ok = cur_hlen >= MIN_HEADER_LEN && cur_total >= {10'd0, cur_hlen};
		msg_len = len_ok ? int'(cur_total) - int'(cur_hlen) : 0;
		payload = (msg_len >= int'(ICMP_HDR_LEN)) ? msg_len - int'(ICMP_HDR_LEN) : 0;

		if (!len_ok || received < int'(cur_total) || msg_len < int'(ICMP_HDR_LEN)) begin
			res.verdict = VERDICT_DROP_SHORT;
		end else if (cur_proto != PROTO_ICMP) begin
			res.verdict = VERDICT_DROP_PROTOCOL;
		end else begin
			s = cur_sum;
			// odd message: pad the last high byte with a zero low byte
			if (msg_len % 2 == 1)
				s = fold_add(s, {cur_high, 8'h00});
			if (!cur_csum_zero && s != SUM_ALL_ONES)
				res.verdict = VERDICT_DROP_CHECKSUM;
			else if (cur_type == TYPE_ECHO_REQUEST && cur_code == CODE_ZERO)
				res.verdict = VERDICT_PASS_ECHO;
			else if (((cur_type == TYPE_DEST_UNREACH &&
				(cur_code == CODE_HOST_UNREACH || cur_code == CODE_PORT_UNREACH)) ||
				(cur_type == TYPE_TIME_EXCEEDED && cur_code == CODE_ZERO)) &&
				payload >= int'(MIN_INNER_LEN))
				res.verdict = VERDICT_PASS_ERROR;
			else
				res.verdict = VERDICT_PASS;
		end

		res.msg_type       = cur_type;
		res.icmp_code      = cur_code;
		res.payload_length = 16'(payload);
		res.echo_ident     = cur_ident;
		res.echo_sequence  = cur_seq;
		res.error_kind     = (cur_type == TYPE_TIME_EXCEEDED);
		res.inner_protocol = cur_inner;
		cur_offset = '0;
		return 1'b1;
	endfunction

	// Write a valid checksum over the ICMP region [hl, total) of the frame.
	function automatic void seal_frame(input int hl, input int total);
		logic [15:0] sum;
		if (hl < int'(MIN_HEADER_LEN) || hl + 4 > total || total > frame.size())
			return;
		frame[hl + 2] = '0;
		frame[hl + 3] = '0;
		sum = '0;
		for (int i = hl; i < total; i += 2)
			sum = fold_add(sum, {frame[i], (i + 1 < total) ? frame[i + 1] : 8'h00});
		sum = ~sum;
		frame[hl + 2] = sum[15:8];
		frame[hl + 3] = sum[7:0];
	endfunction

	// Fill the frame with random bytes around a header of ihl words and the given total length.
	function automatic void build_frame(input int ihl, input int total, input logic [7:0] t,
		input logic [7:0] c);
		int hl;
		int len;
		hl = ihl * 4;
		len = (total < 4) ? 4 : total;
		frame.delete();
		repeat (len) frame.push_back(8'($urandom));
		frame[0] = {4'($urandom), 4'(ihl)};
		frame[2] = 8'(total >> 8);
		frame[3] = 8'(total);
		if (hl >= int'(MIN_HEADER_LEN) && hl + 1 < len) begin
			frame[hl] = t;
			frame[hl + 1] = c;
		end
		seal_frame(hl, total);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic is_last, input logic [7:0] proto);
		result_t want;
		if (src_idling && $urandom_range(0, 99) < 8) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= is_last;
		s_axis_tuser  <= proto;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		if (classify_byte(b, is_last, proto, want))
			pending_verdicts.push_back(want);
	endtask

	// Protocol rides on the first byte; tuser on the others is random and must be ignored.
	task automatic send_packet(input logic [7:0] proto);
		for (int i = 0; i < frame.size(); i++)
			send_byte(frame[i], i == frame.size() - 1, (i == 0) ? proto : 8'($urandom));
	endtask

	task automatic wait_for_verdicts();
		s_axis_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : verdict_check
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_verdicts.size() == 0) begin
				$error("result with no verdict pending: tuser %0d tdata %h",
					m_axis_tuser, m_axis_tdata);
				mismatch_count++;
			end else begin
				want = pending_verdicts.pop_front();
				compare_field("verdict", want.verdict, m_axis_tuser);
				compare_field("msg_type", want.msg_type, m_axis_tdata[7:0]);
				compare_field("icmp_code", want.icmp_code, m_axis_tdata[15:8]);
				compare_field("payload_length", want.payload_length, m_axis_tdata[31:16]);
				compare_field("echo_ident", want.echo_ident, m_axis_tdata[47:32]);
				compare_field("echo_sequence", want.echo_sequence, m_axis_tdata[63:48]);
				compare_field("error_kind", want.error_kind, m_axis_tdata[64]);
				compare_field("inner_protocol", want.inner_protocol, m_axis_tdata[72:65]);
				compare_field("tdata_pad", 0, m_axis_tdata[79:73]);
			end
		end
	end

	// Result sink: a requested hold-off first, otherwise random stalls while sink_idling is set.
	initial begin : sink_drive
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				m_axis_tready <= 1'b0;
				sink_hold--;
			end else begin
				m_axis_tready <= !(sink_idling && $urandom_range(0, 99) < 8);
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("icmp_rx_classifier regression: fail");
		$finish;
	end

	task automatic test_checksum_and_protocol();
		build_frame(5, 28, TYPE_ECHO_REQUEST, CODE_ZERO);
		send_packet(PROTO_ICMP);
		// zero checksum field: random content passes unchecked
		build_frame(5, 28, 8'h00, CODE_ZERO);
		frame[22] = 8'h00;
		frame[23] = 8'h00;
		send_packet(PROTO_ICMP);
		build_frame(5, 36, TYPE_ECHO_REQUEST, CODE_ZERO);
		frame[30] = frame[30] ^ 8'h01;
		send_packet(PROTO_ICMP);
		build_frame(5, 28, TYPE_ECHO_REQUEST, CODE_ZERO);
		send_packet(8'h06);
		send_packet(8'hFF);
		send_packet(8'h00);
		// odd ICMP length exercises the padded last word
		build_frame(5, 29, 8'h00, CODE_ZERO);
		send_packet(PROTO_ICMP);
		build_frame(15, 72, 8'hFF, 8'hFF);
		send_packet(PROTO_ICMP);
		build_frame(5, 28, TYPE_ECHO_REQUEST, CODE_HOST_UNREACH);
		send_packet(PROTO_ICMP);
		wait_for_verdicts();
	endtask

	task automatic test_length_faults();
		build_frame(4, 28, TYPE_ECHO_REQUEST, CODE_ZERO);
		send_packet(PROTO_ICMP);
		build_frame(0, 28, TYPE_ECHO_REQUEST, CODE_ZERO);
		send_packet(PROTO_ICMP);
		// total length below header length
		build_frame(5, 12, TYPE_ECHO_REQUEST, CODE_ZERO);
		send_packet(PROTO_ICMP);
		build_frame(5, 0, TYPE_ECHO_REQUEST, CODE_ZERO);
		send_packet(PROTO_ICMP);
		// stream ends before the total length
		build_frame(5, 40, TYPE_ECHO_REQUEST, CODE_ZERO);
		repeat (5) void'(frame.pop_back());
		send_packet(PROTO_ICMP);
		build_frame(5, 27, TYPE_ECHO_REQUEST, CODE_ZERO);
		send_packet(PROTO_ICMP);
		build_frame(5, 28, 8'h00, CODE_ZERO);
		send_packet(PROTO_ICMP);
		frame.delete();
		frame.push_back(8'h45);
		send_packet(PROTO_ICMP);
		frame.push_back(8'hFF);
		send_packet(PROTO_ICMP);
		// bytes past the total length must not touch the sum
		build_frame(5, 30, TYPE_ECHO_REQUEST, CODE_ZERO);
		repeat (6) frame.push_back(8'($urandom));
		send_packet(PROTO_ICMP);
		wait_for_verdicts();
	endtask

	// Sends its packets with no idling on either side.
	task automatic test_error_reports();
		src_idling = 1'b0;
		sink_idling = 1'b0;
		build_frame(5, 48, TYPE_DEST_UNREACH, CODE_HOST_UNREACH);
		frame[20 + 17] = 8'h11;
		seal_frame(20, 48);
		send_packet(PROTO_ICMP);
		build_frame(5, 48, TYPE_DEST_UNREACH, CODE_PORT_UNREACH);
		send_packet(PROTO_ICMP);
		build_frame(5, 48, TYPE_TIME_EXCEEDED, CODE_ZERO);
		send_packet(PROTO_ICMP);
		// one byte short of a full embedded header
		build_frame(5, 47, TYPE_TIME_EXCEEDED, CODE_ZERO);
		send_packet(PROTO_ICMP);
		build_frame(5, 48, TYPE_DEST_UNREACH, CODE_ZERO);
		send_packet(PROTO_ICMP);
		build_frame(5, 48, TYPE_DEST_UNREACH, 8'h02);
		send_packet(PROTO_ICMP);
		build_frame(5, 48, TYPE_TIME_EXCEEDED, 8'h01);
		send_packet(PROTO_ICMP);
		build_frame(5, 48, TYPE_DEST_UNREACH, CODE_HOST_UNREACH);
		frame[20 + 9] = frame[20 + 9] ^ 8'h80;
		send_packet(PROTO_ICMP);
		build_frame(5, 48, TYPE_DEST_UNREACH, CODE_PORT_UNREACH);
		send_packet(8'h11);
		src_idling = 1'b1;
		sink_idling = 1'b1;
		wait_for_verdicts();
	endtask

	// Hold the sink off while tiny packets pile up behind it.
	task automatic test_backpressure();
		sink_hold = 300;
		repeat (10) begin
			frame.delete();
			repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
			send_packet(8'($urandom));
		end
		build_frame(5, 28, TYPE_ECHO_REQUEST, CODE_ZERO);
		send_packet(PROTO_ICMP);
		wait_for_verdicts();
	endtask

	task automatic test_random_traffic();
		int packets;
		int ihl;
		int hl;
		int msg_len;
		int pick;
		int idx;
		logic [7:0] t;
		logic [7:0] c;
		logic [7:0] proto;
		packets = 0;
		while (bytes_sent < ITEM_TARGET || packets < RANDOM_PACKETS) begin
			if ($urandom_range(0, 99) < 8) begin
				frame.delete();
				repeat ($urandom_range(1, 24)) frame.push_back(8'($urandom));
				proto = 8'($urandom);
			end else begin
				pick = $urandom_range(0, 99);
				ihl = (pick < 75) ? 5 : (pick < 95) ? $urandom_range(6, 15) : $urandom_range(0, 4);
				pick = $urandom_range(0, 99);
				msg_len = (pick < 70) ? $urandom_range(8, 32) :
					(pick < 90) ? $urandom_range(26, 60) : $urandom_range(0, 7);
				case ($urandom_range(0, 4))
					0: t = TYPE_ECHO_REQUEST;
					1: t = TYPE_DEST_UNREACH;
					2: t = TYPE_TIME_EXCEEDED;
					3: t = 8'h00;
					default: t = 8'($urandom);
				endcase
				case ($urandom_range(0, 3))
					0: c = CODE_ZERO;
					1: c = CODE_HOST_UNREACH;
					2: c = CODE_PORT_UNREACH;
					default: c = 8'($urandom);
				endcase
				hl = ihl * 4;
				build_frame(ihl, hl + msg_len, t, c);
				pick = $urandom_range(0, 99);
				if (pick >= 75 && pick < 85 && hl + 4 <= frame.size()) begin
					frame[hl + 2] = 8'h00;
					frame[hl + 3] = 8'h00;
				end else if (pick >= 85 && hl < frame.size()) begin
					idx = $urandom_range(hl, frame.size() - 1);
					frame[idx] = frame[idx] ^ 8'(1 << $urandom_range(0, 7));
				end
				pick = $urandom_range(0, 99);
				if (pick < 6 && frame.size() > 1)
					repeat ($urandom_range(1, frame.size() - 1)) void'(frame.pop_back());
				else if (pick < 12)
					repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom));
				proto = ($urandom_range(0, 99) < 90) ? PROTO_ICMP : 8'($urandom);
			end
			send_packet(proto);
			packets++;
		end
		wait_for_verdicts();
	endtask

	initial begin : run_tests
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_checksum_and_protocol();
		test_length_faults();
		test_error_reports();
		test_backpressure();
		test_random_traffic();
		if (mismatch_count == 0)
			$display("icmp_rx_classifier regression: pass");
		else
			$display("icmp_rx_classifier regression: fail");
		$finish;
	end

endmodule
